// ----- src/raw_frame_length_and_mac_filter_core_macros.svh -----
// Assertion macros shared by the raw frame length and MAC filter RTL.
`ifndef RAW_FRAME_LENGTH_AND_MAC_FILTER_CORE_MACROS_SVH
`define RAW_FRAME_LENGTH_AND_MAC_FILTER_CORE_MACROS_SVH

// The condition must hold whenever the trigger holds, in the same cycle.
`define RFLMF_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("rflmf: same-cycle check failed");

// The condition must hold in the cycle after the trigger holds.
`define RFLMF_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("rflmf: next-cycle check failed");

`endif

// ----- src/rflmf_pkg.sv -----
// Types and constants for the raw frame length and MAC filter.
package rflmf_pkg;

    localparam int unsigned MacBytes    = 6;
    localparam int unsigned HeaderBytes = 2;

    localparam logic [7:0]  MCAST_MASK     = 8'h01;
    localparam logic [15:0] MAC_BYTES_LEN  = 16'(MacBytes);
    localparam logic [15:0] HEADER_LEN     = 16'(HeaderBytes);
    localparam logic [15:0] MAX_LEN_RESET  = 16'd1514;

    localparam int unsigned MacWidth   = 48;
    localparam int unsigned LenWidth   = 16;
    localparam int unsigned CfgWidth   = 48;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_STATION_MAC      = 1'b0,
        CFG_MAX_FRAME_LENGTH = 1'b1
    } cfg_index_t;

    // Frame verdicts carried on the last word of a frame.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FILTERED = 2'd1,
        ST_OVERSIZE = 2'd2,
        ST_RUNT     = 2'd3
    } frame_status_t;

    // One result word.
    typedef struct packed {
        logic          payload_valid;
        logic [7:0]    payload_byte;
        logic          frame_last;
        frame_status_t frame_status;
        logic [15:0]   frame_length;
    } result_t;

endpackage

// ----- src/rflmf_if.sv -----
// Stream interfaces for the receive byte input and the result output.
interface rflmf_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rflmf_res_if;
    logic        valid;
    logic        ready;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_last;
    logic [1:0]  frame_status;
    logic [15:0] frame_length;

    modport source (output valid, output payload_valid, output payload_byte,
                    output frame_last, output frame_status, output frame_length,
                    input ready);
    modport sink (input valid, input payload_valid, input payload_byte,
                  input frame_last, input frame_status, input frame_length,
                  output ready);
endinterface

// ----- src/raw_frame_length_and_mac_filter_core.sv -----
// Top level of the raw frame length and destination MAC filter.
//
//  channel | direction | contents
//  --------+-----------+--------------------------------------------------
//  rx      | in        | rx_byte, one receive buffer byte per word
//  res     | out       | payload_valid, payload_byte, frame_last,
//          |           | frame_status, frame_length
//  cfg     | in        | cfg_we, cfg_index, cfg_wdata (write only)
//
// Each byte is parsed in the cycle in which it is accepted and
// any result lands in the result register at that clock edge.
// The rx side is ready whenever the result register is empty or is being
// drained in the same cycle, so while res is ready words flow one per cycle.
// A stall on res holds the result register and, through it, the rx side.
// Reset puts the parser at the header high byte with the limit at 1514.
`include "raw_frame_length_and_mac_filter_core_macros.svh"

module raw_frame_length_and_mac_filter_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    rflmf_rx_if.sink                         rx,
    rflmf_res_if.source                      res,
    input  logic                             cfg_we,
    input  rflmf_pkg::cfg_index_t            cfg_index,
    input  logic [rflmf_pkg::CfgWidth-1:0]   cfg_wdata
);

    // Parse phases: two header bytes, then pass or skip the payload (a runt has none).
    typedef enum logic [1:0] {
        PH_HDR_HI = 2'd0,
        PH_HDR_LO = 2'd1,
        PH_PASS   = 2'd2,
        PH_SKIP   = 2'd3
    } phase_t;

    // Configuration registers.
    logic [rflmf_pkg::MacWidth-1:0] station_mac_reg;
    logic [rflmf_pkg::LenWidth-1:0] max_len_reg;

    // Parser state.
    phase_t      phase_reg, phase_next;
    logic [7:0]  hdr_hi_reg, hdr_hi_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic        match_reg, match_next;
    logic        mcast_reg, mcast_next;

    // Result register.
    logic                 res_valid_reg;
    rflmf_pkg::result_t   res_reg;
    rflmf_pkg::result_t   res_next;
    logic                 res_emit;

    logic        rx_accept;
    logic [15:0] header;
    logic [15:0] seen_inc;
    logic        frame_done;
    logic [7:0]  mac_byte;
    logic        accept_ok;

    assign rx.ready  = !res_valid_reg || res.ready;
    assign rx_accept = rx.valid && rx.ready;

    assign header   = {hdr_hi_reg, rx.rx_byte};
    assign seen_inc = seen_reg + 16'd1;
    assign frame_done = (seen_inc >= len_reg);

    // Station MAC byte expected at this destination position, first wire
    // byte in the top bits.
    always_comb
    begin
        case (seen_reg[2:0])
            3'd0:    mac_byte = station_mac_reg[47:40];
            3'd1:    mac_byte = station_mac_reg[39:32];
            3'd2:    mac_byte = station_mac_reg[31:24];
            3'd3:    mac_byte = station_mac_reg[23:16];
            3'd4:    mac_byte = station_mac_reg[15:8];
            default: mac_byte = station_mac_reg[7:0];
        endcase
    end

    // Per-byte parse step.
    always_comb
    begin
        phase_next  = phase_reg;
        hdr_hi_next = hdr_hi_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        match_next  = match_reg;
        mcast_next  = mcast_reg;
        res_emit    = 1'b0;
        accept_ok   = 1'b0;
        res_next    = '{payload_valid: 1'b0, payload_byte: 8'd0, frame_last: 1'b0,
                        frame_status: rflmf_pkg::ST_OK, frame_length: 16'd0};

        unique case (phase_reg)
            PH_HDR_HI:
            begin
                hdr_hi_next = rx.rx_byte;
                phase_next  = PH_HDR_LO;
            end
            PH_HDR_LO:
            begin
                seen_next  = 16'd0;
                match_next = 1'b1;
                mcast_next = 1'b0;
                if (header <= rflmf_pkg::HEADER_LEN)
                begin
                    // Runt header: report it and look for the next header.
                    len_next   = 16'd0;
                    phase_next = PH_HDR_HI;
                    res_emit   = 1'b1;
                    res_next.frame_last   = 1'b1;
                    res_next.frame_status = rflmf_pkg::ST_RUNT;
                end
                else
                begin
                    len_next   = header - rflmf_pkg::HEADER_LEN;
                    phase_next = (len_next > max_len_reg) ? PH_SKIP : PH_PASS;
                end
            end
            PH_SKIP:
            begin
                seen_next = seen_inc;
                if (frame_done)
                begin
                    phase_next = PH_HDR_HI;
                    res_emit   = 1'b1;
                    res_next.frame_last   = 1'b1;
                    res_next.frame_status = rflmf_pkg::ST_OVERSIZE;
                    res_next.frame_length = len_reg;
                end
            end
            default: // PH_PASS
            begin
                if (seen_reg == 16'd0)
                begin
                    mcast_next = (rx.rx_byte & rflmf_pkg::MCAST_MASK) != 8'd0;
                end
                if (seen_reg < rflmf_pkg::MAC_BYTES_LEN && mac_byte != rx.rx_byte)
                begin
                    match_next = 1'b0;
                end
                seen_next = seen_inc;
                res_emit  = 1'b1;
                res_next.payload_valid = 1'b1;
                res_next.payload_byte  = rx.rx_byte;
                if (frame_done)
                begin
                    accept_ok  = mcast_next ||
                                 (len_reg >= rflmf_pkg::MAC_BYTES_LEN && match_next);
                    phase_next = PH_HDR_HI;
                    res_next.frame_last   = 1'b1;
                    res_next.frame_status = accept_ok ? rflmf_pkg::ST_OK
                                                      : rflmf_pkg::ST_FILTERED;
                    res_next.frame_length = len_reg;
                end
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_mac_reg <= '0;
            max_len_reg     <= rflmf_pkg::MAX_LEN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rflmf_pkg::CFG_STATION_MAC:
                    station_mac_reg <= cfg_wdata[rflmf_pkg::MacWidth-1:0];
                default:
                    max_len_reg <= cfg_wdata[rflmf_pkg::LenWidth-1:0];
            endcase
        end
    end

    // Parser state, advanced once per accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR_HI;
            hdr_hi_reg <= 8'd0;
            len_reg    <= 16'd0;
            seen_reg   <= 16'd0;
            match_reg  <= 1'b1;
            mcast_reg  <= 1'b0;
        end
        else if (rx_accept)
        begin
            phase_reg  <= phase_next;
            hdr_hi_reg <= hdr_hi_next;
            len_reg    <= len_next;
            seen_reg   <= seen_next;
            match_reg  <= match_next;
            mcast_reg  <= mcast_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rx_accept && res_emit)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (rx_accept && res_emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.payload_valid = res_reg.payload_valid;
    assign res.payload_byte  = res_reg.payload_byte;
    assign res.frame_last    = res_reg.frame_last;
    assign res.frame_status  = res_reg.frame_status;
    assign res.frame_length  = res_reg.frame_length;

    // A word in the middle of a frame carries no status or length.
    `RFLMF_ASSERT_SAME(a_mid_frame_clean, clk, rst_n,
        res_valid_reg && !res_reg.frame_last,
        res_reg.frame_status == rflmf_pkg::ST_OK && res_reg.frame_length == 16'd0)

    // A status-only word always closes a frame.
    `RFLMF_ASSERT_SAME(a_status_only_last, clk, rst_n,
        res_valid_reg && !res_reg.payload_valid,
        res_reg.frame_last && res_reg.payload_byte == 8'd0)

    // While a payload is in flight the byte count stays below its length.
    `RFLMF_ASSERT_SAME(a_count_in_range, clk, rst_n,
        phase_reg == PH_PASS || phase_reg == PH_SKIP,
        seen_reg < len_reg)

    // The header high byte always moves the parser to the low byte.
    `RFLMF_ASSERT_NEXT(a_hdr_hi_step, clk, rst_n,
        rx_accept && phase_reg == PH_HDR_HI,
        phase_reg == PH_HDR_LO)

endmodule
